// ===== hdl/prp_pkg.sv =====
// ----------------------------------------------------------------------------
// Pixel replication upscaler package
// Shared constants, the command item passed from front to back, and the
// helpers that clamp the configured scale and line width.
// ----------------------------------------------------------------------------
package prp_pkg;

  localparam int MAX_WIDTH = 64;
  localparam int MAX_SCALE = 16;

  localparam int ColW   = 7;
  localparam int ScaleW = 5;
  localparam int AddrW  = $clog2(MAX_WIDTH);
  localparam int IdxW   = $clog2(MAX_SCALE);
  localparam int ChanW  = 8;
  localparam int RgbW   = 3 * ChanW;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] REG_SCALE_FACTOR = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_LINE_WIDTH   = 1'b1;

  localparam logic FUNC_PIXEL  = 1'b0;
  localparam logic FUNC_REPLAY = 1'b1;

  typedef struct packed {
    logic [RgbW-1:0] rgb;
    logic            reject;
    logic            row_end;
  } prp_cmd_t;

  function automatic logic [ScaleW-1:0] eff_scale(input logic [ScaleW-1:0] sf);
    logic [ScaleW-1:0] s;
    s = sf;
    if (s == '0) s = ScaleW'(1);
    if (s > ScaleW'(MAX_SCALE)) s = ScaleW'(MAX_SCALE);
    return s;
  endfunction

  function automatic logic [ColW-1:0] eff_width(input logic [ColW-1:0] lw);
    logic [ColW-1:0] w;
    w = lw;
    if (w == '0) w = ColW'(1);
    if (w > ColW'(MAX_WIDTH)) w = ColW'(MAX_WIDTH);
    return w;
  endfunction

endpackage

// ===== hdl/prp_front.sv =====
// ----------------------------------------------------------------------------
// Upscaler front end
// Accepts items, keeps the row counters and the line store, and turns each
// item that has results into a command for the back end.
// ----------------------------------------------------------------------------
module prp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       func,
  input  logic [prp_pkg::ChanW-1:0]  red_in,
  input  logic [prp_pkg::ChanW-1:0]  green_in,
  input  logic [prp_pkg::ChanW-1:0]  blue_in,
  input  logic [prp_pkg::ScaleW-1:0] scale_eff,
  input  logic [prp_pkg::ColW-1:0]   width_eff,
  output logic                       push,
  output prp_pkg::prp_cmd_t          push_cmd,
  input  logic                       q_full
);
  import prp_pkg::*;

  logic [RgbW-1:0] line_mem [MAX_WIDTH];

  logic [ColW-1:0]   write_column_r, write_column_nxt;
  logic [ScaleW-1:0] replays_left_r, replays_left_nxt;
  logic [ColW-1:0]   replay_column_r, replay_column_nxt;

  logic            s1_valid_r, s1_valid_nxt;
  logic            s1_reject_r, s1_use_mem_r, s1_oor_r, s1_row_end_r;
  logic [RgbW-1:0] s1_pix_r, mem_rd_r;

  logic            accept;
  logic [RgbW-1:0] pix;
  logic            is_pixel, is_reject, is_run, is_replay, row_end;
  logic [ColW:0]   wc_inc, rc_inc;

  assign in_stall = s1_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = s1_valid_r && !q_full;
  assign pix      = {red_in, green_in, blue_in};

  assign wc_inc = {1'b0, write_column_r} + 1'b1;
  assign rc_inc = {1'b0, replay_column_r} + 1'b1;

  always_comb begin
    is_pixel  = (func == FUNC_PIXEL);
    is_reject = is_pixel && (replays_left_r != '0);
    is_run    = is_pixel && (replays_left_r == '0);
    is_replay = (func == FUNC_REPLAY) && (replays_left_r != '0);
    row_end   = 1'b0;
    write_column_nxt  = write_column_r;
    replays_left_nxt  = replays_left_r;
    replay_column_nxt = replay_column_r;
    if (accept && is_run) begin
      row_end = (wc_inc >= {1'b0, width_eff});
      if (row_end) begin
        write_column_nxt  = '0;
        replays_left_nxt  = scale_eff - 1'b1;
        replay_column_nxt = '0;
      end else begin
        write_column_nxt = wc_inc[ColW-1:0];
      end
    end else if (accept && is_replay) begin
      row_end = (rc_inc >= {1'b0, width_eff});
      if (row_end) begin
        replay_column_nxt = '0;
        replays_left_nxt  = replays_left_r - 1'b1;
      end else begin
        replay_column_nxt = rc_inc[ColW-1:0];
      end
    end
    s1_valid_nxt = s1_valid_r && !push;
    if (accept) s1_valid_nxt = is_reject || is_run || is_replay;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_column_r  <= '0;
      replays_left_r  <= '0;
      replay_column_r <= '0;
      s1_valid_r      <= 1'b0;
    end else begin
      write_column_r  <= write_column_nxt;
      replays_left_r  <= replays_left_nxt;
      replay_column_r <= replay_column_nxt;
      s1_valid_r      <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_run && (write_column_r < ColW'(MAX_WIDTH))) begin
      line_mem[write_column_r[AddrW-1:0]] <= pix;
    end
    if (accept) begin
      mem_rd_r     <= line_mem[replay_column_r[AddrW-1:0]];
      s1_oor_r     <= (replay_column_r >= ColW'(MAX_WIDTH));
      s1_reject_r  <= is_reject;
      s1_use_mem_r <= is_replay;
      s1_row_end_r <= row_end;
      s1_pix_r     <= pix;
    end
  end

  always_comb begin
    push_cmd.reject  = s1_reject_r;
    push_cmd.row_end = s1_row_end_r;
    if (s1_reject_r) push_cmd.rgb = '0;
    else if (s1_use_mem_r) push_cmd.rgb = s1_oor_r ? '0 : mem_rd_r;
    else push_cmd.rgb = s1_pix_r;
  end

endmodule

// ===== hdl/prp_queue.sv =====
// ----------------------------------------------------------------------------
// Upscaler command queue
// Short FIFO of commands between the front end and the back end.
// ----------------------------------------------------------------------------
module prp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  prp_pkg::prp_cmd_t push_cmd,
  input  logic              pop,
  output prp_pkg::prp_cmd_t head,
  output logic              empty,
  output logic              full
);
  import prp_pkg::*;

  prp_cmd_t         q_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCntW'(QDepth));
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// ===== hdl/prp_back.sv =====
// ----------------------------------------------------------------------------
// Upscaler back end
// Expands the command at the queue head into its run of output copies, one
// per cycle while out_stall allows, through the output register.
// ----------------------------------------------------------------------------
module prp_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  prp_pkg::prp_cmd_t          head,
  input  logic                       empty,
  output logic                       pop,
  input  logic [prp_pkg::ScaleW-1:0] scale_eff,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [prp_pkg::ChanW-1:0]  red_out,
  output logic [prp_pkg::ChanW-1:0]  green_out,
  output logic [prp_pkg::ChanW-1:0]  blue_out,
  output logic                       last_of_run,
  output logic                       end_of_line,
  output logic                       rejected
);
  import prp_pkg::*;

  logic            out_valid_r;
  logic [RgbW-1:0] rgb_r;
  logic            last_r, eol_r, rej_r;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic            slot_free, load, last;
  logic [ScaleW:0] idx_inc;

  assign slot_free = !out_valid_r || !out_stall;
  assign load      = slot_free && !empty;
  assign idx_inc   = (ScaleW+1)'(idx_r) + 1'b1;
  assign last      = head.reject || (idx_inc >= {1'b0, scale_eff});
  assign pop       = load && last;

  always_comb begin
    idx_nxt = idx_r;
    if (load) idx_nxt = last ? '0 : idx_inc[IdxW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (slot_free) out_valid_r <= !empty;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rgb_r  <= head.rgb;
      last_r <= last;
      eol_r  <= last && head.row_end && !head.reject;
      rej_r  <= head.reject;
    end
  end

  assign out_valid   = out_valid_r;
  assign red_out     = rgb_r[RgbW-1 -: ChanW];
  assign green_out   = rgb_r[2*ChanW-1 -: ChanW];
  assign blue_out    = rgb_r[ChanW-1:0];
  assign last_of_run = last_r;
  assign end_of_line = eol_r;
  assign rejected    = rej_r;

endmodule

// ===== hdl/pixel_replication_upscaler_top.sv =====
// ----------------------------------------------------------------------------
// Pixel replication upscaler
// Nearest-neighbor integer upscaler for 8-bit RGB pixels.
//
// Input channel (in_valid/in_stall): func 0 carries a pixel, which is stored
// in the line buffer and sent out scale times; func 1 asks for the next
// replayed pixel of the last full row. A pixel that arrives while replays are
// pending gives one result with rejected set. A replay with none pending
// gives nothing.
// Output channel (out_valid/out_stall): one copy per cycle unless stalled;
// last_of_run marks the final copy of an item and end_of_line the final
// pixel of a row. Config port (cfg_valid/cfg_ready, always ready): index 0
// scale_factor, index 1 line_width; write only while the block is idle.
// An item gives scale copies (one for a rejected pixel); the input takes
// one item per cycle while the 4-entry command queue has room, so the
// output port sets the sustained rate. Reset clears counters, queue and
// output; the line buffer is not cleared. When out_stall is high the output
// holds, the queue fills and then in_stall rises.
// ----------------------------------------------------------------------------
module pixel_replication_upscaler_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [prp_pkg::ChanW-1:0]    in_red_in,
  input  logic [prp_pkg::ChanW-1:0]    in_green_in,
  input  logic [prp_pkg::ChanW-1:0]    in_blue_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [prp_pkg::ChanW-1:0]    out_red_out,
  output logic [prp_pkg::ChanW-1:0]    out_green_out,
  output logic [prp_pkg::ChanW-1:0]    out_blue_out,
  output logic                         out_last_of_run,
  output logic                         out_end_of_line,
  output logic                         out_rejected,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [prp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [prp_pkg::CfgDataW-1:0] cfg_data
);
  import prp_pkg::*;

  logic [ScaleW-1:0] scale_factor_r;
  logic [ColW-1:0]   line_width_r;
  logic [ScaleW-1:0] scale_eff;
  logic [ColW-1:0]   width_eff;

  logic     push, pop, q_full, q_empty;
  prp_cmd_t push_cmd, head;

  assign cfg_ready = 1'b1;
  assign scale_eff = eff_scale(scale_factor_r);
  assign width_eff = eff_width(line_width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_factor_r <= ScaleW'(1);
      line_width_r   <= ColW'(MAX_WIDTH);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCALE_FACTOR: scale_factor_r <= cfg_data[ScaleW-1:0];
        REG_LINE_WIDTH:   line_width_r   <= cfg_data[ColW-1:0];
        default: ;
      endcase
    end
  end

  prp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (in_func),
    .red_in    (in_red_in),
    .green_in  (in_green_in),
    .blue_in   (in_blue_in),
    .scale_eff (scale_eff),
    .width_eff (width_eff),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  prp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  prp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .empty       (q_empty),
    .pop         (pop),
    .scale_eff   (scale_eff),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red_out     (out_red_out),
    .green_out   (out_green_out),
    .blue_out    (out_blue_out),
    .last_of_run (out_last_of_run),
    .end_of_line (out_end_of_line),
    .rejected    (out_rejected)
  );

endmodule

// ===== hdl/prp_checker.sv =====
// ----------------------------------------------------------------------------
// Upscaler port checker
// Watches the top-level ports for reset behavior, output hold under stall
// and consistency of the result flags.
// ----------------------------------------------------------------------------
module prp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [prp_pkg::ChanW-1:0]   out_red_out,
  input logic [prp_pkg::ChanW-1:0]   out_green_out,
  input logic [prp_pkg::ChanW-1:0]   out_blue_out,
  input logic                        out_last_of_run,
  input logic                        out_end_of_line,
  input logic                        out_rejected
);
  import prp_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_out)
      && $stable(out_green_out) && $stable(out_blue_out)
      && $stable(out_last_of_run) && $stable(out_rejected))
    else $error("stalled item changed");

  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_last_of_run && !out_end_of_line
      && out_red_out == '0 && out_green_out == '0 && out_blue_out == '0)
    else $error("malformed rejected item");

  a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_line |-> out_last_of_run)
    else $error("end of line without end of run");

endmodule

bind pixel_replication_upscaler_top prp_checker u_prp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_red_out     (out_red_out),
  .out_green_out   (out_green_out),
  .out_blue_out    (out_blue_out),
  .out_last_of_run (out_last_of_run),
  .out_end_of_line (out_end_of_line),
  .out_rejected    (out_rejected)
);

// ===== dv/tb_pixel_replication_upscaler_top.sv =====
// ----------------------------------------------------------------------------
// Pixel replication upscaler testbench
// Drives pixel and replay items into the upscaler with random gaps and output
// back-pressure. A scoreboard predicts every output copy from its own line
// buffer and counters, and checks each copy in order. A directed table covers
// register extremes, rejection and width changes; random rows follow.
// ----------------------------------------------------------------------------
module tb_pixel_replication_upscaler_top;
  import prp_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 33;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             last;
    logic             eol;
    logic             rej;
  } copy_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic                func;
    logic [RgbW-1:0]     rgb;
    row_check_t          check;
    copy_t               want;
  } stim_row_t;

  localparam copy_t REJECT_COPY = '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1};
  localparam int    NUM_ROWS    = 26;

  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_ITEM, REG_SCALE_FACTOR, 7'd0, FUNC_PIXEL, 24'hFF00AA, CHK_ONE,
      '{8'hFF, 8'h00, 8'hAA, 1'b1, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_SCALE_FACTOR, 7'd0, FUNC_REPLAY, 24'hFFFFFF, CHK_NONE, '0},
    '{ROW_ITEM, REG_SCALE_FACTOR, 7'd0, FUNC_PIXEL, 24'h00FF55, CHK_ONE,
      '{8'h00, 8'hFF, 8'h55, 1'b1, 1'b0, 1'b0}},
    '{ROW_CFG, REG_LINE_WIDTH, 7'd2, FUNC_PIXEL, 24'h0, CHK_NONE, '0},
    '{ROW_ITEM, REG_SCALE_FACTOR, 7'd0, FUNC_PIXEL, 24'h123456, CHK_ONE,
      '{8'h12, 8'h34, 8'h56, 1'b1, 1'b1, 1'b0}},
    '{ROW_CFG, REG_SCALE_FACTOR, 7'd0, FUNC_PIXEL, 24'h0, CHK_NONE, '0},
    '{ROW_CFG, REG_LINE_WIDTH, 7'd0, FUNC_PIXEL, 24'h0, CHK_NONE, '0},
    '{ROW_ITEM, REG_SCALE_FACTOR, 7'd0, FUNC_PIXEL, 24'h807F01, CHK_ONE,
      '{8'h80, 8'h7F, 8'h01, 1'b1, 1'b1, 1'b0}},
    '{ROW_CFG, REG_SCALE_FACTOR, 7'h62, FUNC_PIXEL, 24'h0, CHK_NONE, '0},
    '{ROW_CFG, REG_LINE_WIDTH, 7'd3, FUNC_PIXEL, 24'h0, CHK_NONE, '0},
    '{ROW_ITEM, REG_SCALE_FACTOR, 7'd0, FUNC_PIXEL, 24'h010204, CHK_MODEL, '0},
    '{ROW_ITEM, REG_SCALE_FACTOR, 7'd0, FUNC_PIXEL, 24'h081020, CHK_MODEL, '0},
    '{ROW_ITEM, REG_SCALE_FACTOR, 7'd0, FUNC_PIXEL, 24'h4080FF, CHK_MODEL, '0},
    '{ROW_ITEM, REG_SCALE_FACTOR, 7'd0, FUNC_PIXEL, 24'hAA55CC, CHK_ONE, REJECT_COPY},
    '{ROW_ITEM, REG_SCALE_FACTOR, 7'd0, FUNC_REPLAY, 24'h0, CHK_MODEL, '0},
    '{ROW_CFG, REG_LINE_WIDTH, 7'd1, FUNC_PIXEL, 24'h0, CHK_NONE, '0},
    '{ROW_ITEM, REG_SCALE_FACTOR, 7'd0, FUNC_REPLAY, 24'h0, CHK_MODEL, '0},
    '{ROW_ITEM, REG_SCALE_FACTOR, 7'd0, FUNC_REPLAY, 24'hFFFFFF, CHK_NONE, '0},
    '{ROW_CFG, REG_SCALE_FACTOR, 7'd16, FUNC_PIXEL, 24'h0, CHK_NONE, '0},
    '{ROW_CFG, REG_LINE_WIDTH, 7'd64, FUNC_PIXEL, 24'h0, CHK_NONE, '0},
    '{ROW_ITEM, REG_SCALE_FACTOR, 7'd0, FUNC_PIXEL, 24'hFFFFFF, CHK_MODEL, '0},
    '{ROW_ITEM, REG_SCALE_FACTOR, 7'd0, FUNC_PIXEL, 24'h000000, CHK_MODEL, '0},
    '{ROW_CFG, REG_SCALE_FACTOR, 7'h1F, FUNC_PIXEL, 24'h0, CHK_NONE, '0},
    '{ROW_CFG, REG_LINE_WIDTH, 7'd1, FUNC_PIXEL, 24'h0, CHK_NONE, '0},
    '{ROW_ITEM, REG_SCALE_FACTOR, 7'd0, FUNC_PIXEL, 24'h5AA53C, CHK_MODEL, '0},
    '{ROW_ITEM, REG_SCALE_FACTOR, 7'd0, FUNC_PIXEL, 24'h000000, CHK_ONE, REJECT_COPY}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_func = FUNC_PIXEL;
  logic [ChanW-1:0]    in_red_in = '0;
  logic [ChanW-1:0]    in_green_in = '0;
  logic [ChanW-1:0]    in_blue_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ChanW-1:0]    out_red_out;
  logic [ChanW-1:0]    out_green_out;
  logic [ChanW-1:0]    out_blue_out;
  logic                out_last_of_run;
  logic                out_end_of_line;
  logic                out_rejected;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // scoreboard copy of the upscaler state
  logic [RgbW-1:0]   line_mem [MAX_WIDTH];
  logic              line_written [MAX_WIDTH];
  logic [ColW-1:0]   wr_col = '0;
  logic [ScaleW-1:0] rows_pending = '0;
  logic [ColW-1:0]   rd_col = '0;
  logic [ScaleW-1:0] scale_reg = ScaleW'(1);
  logic [ColW-1:0]   width_reg = ColW'(64);

  copy_t pred_copies [$];
  copy_t copy_expect [$];

  int mismatches = 0;
  int tx_idle_pct = 13;
  int rx_idle_pct = 47;
  int hold_left = 0;
  int quiet_cycles = 0;

  pixel_replication_upscaler_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_red_in       (in_red_in),
    .in_green_in     (in_green_in),
    .in_blue_in      (in_blue_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red_out     (out_red_out),
    .out_green_out   (out_green_out),
    .out_blue_out    (out_blue_out),
    .out_last_of_run (out_last_of_run),
    .out_end_of_line (out_end_of_line),
    .out_rejected    (out_rejected),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int copies_per_item(input logic [ScaleW-1:0] v);
    int s;
    s = int'(v);
    if (s == 0) s = 1;
    if (s > MAX_SCALE) s = MAX_SCALE;
    return s;
  endfunction

  function automatic int pixels_per_row(input logic [ColW-1:0] v);
    int w;
    w = int'(v);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int written_prefix();
    int n;
    n = 0;
    while (n < MAX_WIDTH && line_written[n] === 1'b1) n++;
    return n;
  endfunction

  task automatic predict_upscale(input logic func, input logic [RgbW-1:0] rgb);
    int s;
    int w;
    int k;
    logic emit;
    logic row_end;
    logic [RgbW-1:0] pix;
    copy_t c;
    pred_copies.delete();
    s = copies_per_item(scale_reg);
    w = pixels_per_row(width_reg);
    emit = 1'b0;
    row_end = 1'b0;
    pix = '0;
    if (func == FUNC_PIXEL) begin
      if (rows_pending != 0) begin
        pred_copies.push_back(REJECT_COPY);
      end else begin
        if (wr_col < MAX_WIDTH) begin
          line_mem[wr_col[AddrW-1:0]] = rgb;
          line_written[wr_col[AddrW-1:0]] = 1'b1;
        end
        pix = rgb;
        emit = 1'b1;
        row_end = (int'(wr_col) + 1 >= w);
        if (row_end) begin
          wr_col = '0;
          rows_pending = ScaleW'(s - 1);
          rd_col = '0;
        end else begin
          wr_col = wr_col + 1'b1;
        end
      end
    end else if (rows_pending != 0) begin
      pix = (rd_col < MAX_WIDTH) ? line_mem[rd_col[AddrW-1:0]] : '0;
      emit = 1'b1;
      row_end = (int'(rd_col) + 1 >= w);
      if (row_end) begin
        rd_col = '0;
        rows_pending = rows_pending - 1'b1;
      end else begin
        rd_col = rd_col + 1'b1;
      end
    end
    if (emit) begin
      for (k = 0; k < s; k++) begin
        c.red   = pix[23:16];
        c.green = pix[15:8];
        c.blue  = pix[7:0];
        c.last  = (k == s - 1);
        c.eol   = (k == s - 1) && row_end;
        c.rej   = 1'b0;
        pred_copies.push_back(c);
      end
    end
  endtask

  // caller stands at a rising edge
  task automatic send_item(input logic func, input logic [RgbW-1:0] rgb,
                           input row_check_t check, input copy_t want);
    int gap;
    in_valid    <= 1'b1;
    in_func     <= func;
    in_red_in   <= rgb[23:16];
    in_green_in <= rgb[15:8];
    in_blue_in  <= rgb[7:0];
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_upscale(func, rgb);
    if (check == CHK_MODEL) begin
      foreach (pred_copies[i]) copy_expect.push_back(pred_copies[i]);
    end else if (check == CHK_ONE) begin
      copy_expect.push_back(want);
    end
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid and wait for the block to drain
  task automatic settle();
    in_valid <= 1'b0;
    while (copy_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == REG_SCALE_FACTOR) scale_reg = data[ScaleW-1:0];
    else width_reg = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_copy();
    copy_t got;
    copy_t want;
    got = {out_red_out, out_green_out, out_blue_out,
           out_last_of_run, out_end_of_line, out_rejected};
    if (copy_expect.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected copy: rgb=%h%h%h last=%b eol=%b rej=%b",
                 got.red, got.green, got.blue, got.last, got.eol, got.rej);
    end else begin
      want = copy_expect.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.last !== want.last || got.eol !== want.eol || got.rej !== want.rej) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"copy mismatch: exp rgb=%h%h%h last=%b eol=%b rej=%b,",
                    " got rgb=%h%h%h last=%b eol=%b rej=%b"},
                   want.red, want.green, want.blue, want.last, want.eol, want.rej,
                   got.red, got.green, got.blue, got.last, got.eol, got.rej);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) check_copy();
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_pixel_replication_upscaler_top NOT OK");
      $finish;
    end
  end

  initial begin
    int phase;
    int done;
    int w;
    logic func;
    logic [CfgDataW-1:0] sdata;
    logic [CfgDataW-1:0] wdata;
    foreach (line_written[i]) line_written[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        settle();
        cfg_write(DIRECTED[r].idx, DIRECTED[r].data);
      end else begin
        send_item(DIRECTED[r].func, DIRECTED[r].rgb, DIRECTED[r].check, DIRECTED[r].want);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase / 4)
        0: begin tx_idle_pct = 13; rx_idle_pct = 47; end
        1: begin tx_idle_pct = 47; rx_idle_pct = 13; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      settle();
      case ($urandom_range(7))
        0: sdata = '0;
        1: sdata = CfgDataW'(MAX_SCALE);
        2: sdata = CfgDataW'($urandom_range(17, 127));
        default: sdata = CfgDataW'($urandom_range(1, 4));
      endcase
      case ($urandom_range(7))
        0: wdata = '0;
        1: wdata = CfgDataW'(MAX_WIDTH);
        2: wdata = CfgDataW'($urandom_range(65, 127));
        default: wdata = CfgDataW'($urandom_range(1, 6));
      endcase
      // keep pending replays inside columns that hold data
      w = written_prefix();
      if (rows_pending != 0 && pixels_per_row(wdata) > w) wdata = CfgDataW'(w);
      cfg_write(REG_SCALE_FACTOR, sdata);
      cfg_write(REG_LINE_WIDTH, wdata);
      if (phase == 2) hold_left = HOLD_CYCLES;
      done = 0;
      while (done < PHASE_ITEMS) begin
        if (rows_pending != 0) func = ($urandom_range(9) < 9) ? FUNC_REPLAY : FUNC_PIXEL;
        else func = ($urandom_range(9) < 9) ? FUNC_PIXEL : FUNC_REPLAY;
        send_item(func, RgbW'($urandom), CHK_MODEL, '0);
        done++;
      end
    end

    settle();
    if (mismatches == 0 && copy_expect.size() == 0) begin
      $display("tb_pixel_replication_upscaler_top OK");
    end else begin
      $display("tb_pixel_replication_upscaler_top NOT OK");
    end
    $finish;
  end

endmodule
